// ===== hdl/tlbpt_pkg.sv =====
`default_nettype none

package tlbpt_pkg;

   localparam int ADDR_BITS     = 16;
   localparam int OFFSET_BITS   = 8;
   localparam int TLB_ENTRIES   = 16;
   localparam int PAGE_COUNT    = 256;
   localparam int FRAME_BITS    = 8;
   localparam int FRAME_CTR_BITS = 9;
   localparam int COUNT_BITS    = 16;

   localparam int PAGE_IDX_BITS = $clog2(PAGE_COUNT);
   localparam int TLB_IDX_BITS  = $clog2(TLB_ENTRIES);

   typedef logic [PAGE_IDX_BITS-1:0] page_idx_type;
   typedef logic [FRAME_BITS-1:0]    frame_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] logical_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  physical_address;
      logic                  tlb_hit;
      logic                  page_fault;
      logic [COUNT_BITS-1:0] hit_count;
      logic [COUNT_BITS-1:0] fault_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/tlbpt_channels.sv =====
`default_nettype none

interface tlbpt_req_if;
   logic               valid;
   logic               ready;
   tlbpt_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tlbpt_rsp_if;
   logic               valid;
   logic               ready;
   tlbpt_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/tlb_page_table_translator.sv =====
// Pipeline: an accepted item is captured in stage 1 together with its page table read, then
// the TLB lookup / resolve writes the result register, where it waits until it is taken.
// Throughput: one item per cycle while the result side is ready; the page table has one read
// and one write port, and a write-to-read bypass lets a frame allocated by one item reach
// the next. A waiting result holds stage 1; input ready drops once stage 1 is also full.
// Reset (sync, active high): TLB and page-table valid bits, frame counter, counts cleared.
`default_nettype none

module tlb_page_table_translator (
   input  wire logic   clock,
   input  wire logic   reset,
   tlbpt_req_if.sink   req_if,
   tlbpt_rsp_if.source rsp_if
);

   // ---------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;        // stage-1 item resolves into the result register
   logic accept;         // new item enters stage 1

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign accept = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------
   // Stage 1: captured address plus page table read data
   // ---------------------------------------------------------------
   logic [tlbpt_pkg::ADDR_BITS-1:0] s1_addr_ff;
   tlbpt_pkg::page_idx_type         in_page;
   tlbpt_pkg::page_idx_type         s1_page;
   logic [tlbpt_pkg::OFFSET_BITS-1:0] s1_offset;

   // Page number reduced modulo the table size (table size is a power of two).
   assign in_page   = req_if.payload.logical_address[tlbpt_pkg::OFFSET_BITS +:
                                                      tlbpt_pkg::PAGE_IDX_BITS];
   assign s1_page   = s1_addr_ff[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::PAGE_IDX_BITS];
   assign s1_offset = s1_addr_ff[tlbpt_pkg::OFFSET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= req_if.payload.logical_address;
      end
   end

   // ---------------------------------------------------------------
   // Frame allocator and saturating statistics registers
   // ---------------------------------------------------------------
   logic [tlbpt_pkg::FRAME_CTR_BITS-1:0] next_frame_ff;
   logic [tlbpt_pkg::COUNT_BITS-1:0]     hits_ff;
   logic [tlbpt_pkg::COUNT_BITS-1:0]     faults_ff;
   logic [tlbpt_pkg::COUNT_BITS-1:0]     hits_in;
   logic [tlbpt_pkg::COUNT_BITS-1:0]     faults_in;

   // ---------------------------------------------------------------
   // Page table: frame memory (contents undefined until written) and
   // per-page valid flops (cleared on reset).
   // ---------------------------------------------------------------
   tlbpt_pkg::frame_type            page_table [tlbpt_pkg::PAGE_COUNT];
   logic [tlbpt_pkg::PAGE_COUNT-1:0] page_valid_ff;
   tlbpt_pkg::frame_type            pt_rd_ff;
   logic                            fwd_hit_ff;
   tlbpt_pkg::frame_type            fwd_frame_ff;

   logic                 pt_wr_en;
   tlbpt_pkg::frame_type new_frame;
   tlbpt_pkg::frame_type frame;

   assign new_frame = next_frame_ff[tlbpt_pkg::FRAME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (pt_wr_en) begin
         page_table[s1_page] <= new_frame;
      end
      if (accept) begin
         pt_rd_ff <= page_table[in_page];
      end
   end

   // A fault write landing on the same edge as the read of the same page
   // returns stale data from the array, so the written frame is forwarded.
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_hit_ff   <= pt_wr_en && (s1_page == in_page);
         fwd_frame_ff <= new_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_valid_ff <= '0;
      end else if (pt_wr_en) begin
         page_valid_ff[s1_page] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // TLB: shift-register FIFO, newest entry at index 0
   // ---------------------------------------------------------------
   tlbpt_pkg::page_idx_type           tlb_page_ff  [tlbpt_pkg::TLB_ENTRIES];
   tlbpt_pkg::frame_type              tlb_frame_ff [tlbpt_pkg::TLB_ENTRIES];
   logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_valid_ff;

   logic                 tlb_hit;
   tlbpt_pkg::frame_type tlb_frame;

   // Fully associative compare; lowest (newest) matching entry wins.
   always_comb begin
      tlb_hit   = 1'b0;
      tlb_frame = '0;
      for (int k = tlbpt_pkg::TLB_ENTRIES - 1; k >= 0; k--) begin
         if (tlb_valid_ff[k] && (tlb_page_ff[k] == s1_page)) begin
            tlb_hit   = 1'b1;
            tlb_frame = tlb_frame_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Resolve: hit, page-table hit, or fault with new frame allocation
   // ---------------------------------------------------------------
   logic page_present;
   logic fault;

   assign page_present = page_valid_ff[s1_page];
   assign fault        = !tlb_hit && !page_present;
   assign pt_wr_en     = advance && fault;

   always_comb begin
      if (tlb_hit) begin
         frame = tlb_frame;
      end else if (page_present) begin
         frame = fwd_hit_ff ? fwd_frame_ff : pt_rd_ff;
      end else begin
         frame = new_frame;
      end
   end

   // Misses only: push page/frame, oldest entry falls off the end.
   always_ff @(posedge clock) begin
      if (advance && !tlb_hit) begin
         for (int k = tlbpt_pkg::TLB_ENTRIES - 1; k > 0; k--) begin
            tlb_page_ff[k]  <= tlb_page_ff[k-1];
            tlb_frame_ff[k] <= tlb_frame_ff[k-1];
         end
         tlb_page_ff[0]  <= s1_page;
         tlb_frame_ff[0] <= frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff <= '0;
      end else if (advance && !tlb_hit) begin
         tlb_valid_ff <= {tlb_valid_ff[tlbpt_pkg::TLB_ENTRIES-2:0], 1'b1};
      end
   end

   // ---------------------------------------------------------------
   // Frame allocator and saturating statistics
   // ---------------------------------------------------------------
   always_comb begin
      hits_in   = hits_ff;
      faults_in = faults_ff;
      if (tlb_hit && (hits_ff != '1)) begin
         hits_in = hits_ff + 1'b1;
      end
      if (fault && (faults_ff != '1)) begin
         faults_in = faults_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_frame_ff <= '0;
         hits_ff       <= '0;
         faults_ff     <= '0;
      end else if (advance) begin
         if (fault) begin
            next_frame_ff <= next_frame_ff + 1'b1;   // wraps modulo the counter width
         end
         hits_ff   <= hits_in;
         faults_ff <= faults_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   tlbpt_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.physical_address <= tlbpt_pkg::ADDR_BITS'({frame, s1_offset});
         rsp_data_ff.tlb_hit          <= tlb_hit;
         rsp_data_ff.page_fault       <= fault;
         rsp_data_ff.hit_count        <= hits_in;
         rsp_data_ff.fault_count      <= faults_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tlb_page_table_translator_test.sv =====
`timescale 1ns / 1ps

module tlb_page_table_translator_test;

   // Every cycle count below assumes a 10 ns clock.
   localparam int CYCLE_LIMIT  = 200000;  // watchdog limit for the whole run
   localparam int PHASE_ITEMS  = 610;     // random items per phase
   localparam int HOT_SPAN     = 24;      // pages in the thrash window, > TLB_ENTRIES
   localparam int RECENT_DEPTH = 8;       // recent pages, mostly still in the TLB
   localparam int HOLD_CYCLES  = 400;     // long receiver hold-off in the last phase
   localparam int DRAIN_CYCLES = 8;       // extra wait after the last response is checked

   // ---------------------------------------------------------------------------
   // Translation predictor and response scoreboard.
   // The class keeps its own TLB, page table, frame counter and saturating
   // counts. Each accepted request is translated right away and the expected
   // response is queued; each accepted response is checked against the oldest.
   // ---------------------------------------------------------------------------
   class translation_scoreboard;
      tlbpt_pkg::page_idx_type              tlb_page  [tlbpt_pkg::TLB_ENTRIES];
      tlbpt_pkg::frame_type                 tlb_frame [tlbpt_pkg::TLB_ENTRIES];
      bit                                   tlb_valid [tlbpt_pkg::TLB_ENTRIES];
      tlbpt_pkg::frame_type                 page_frame[tlbpt_pkg::PAGE_COUNT];
      bit                                   page_valid[tlbpt_pkg::PAGE_COUNT];
      logic [tlbpt_pkg::FRAME_CTR_BITS-1:0] next_frame;
      logic [tlbpt_pkg::COUNT_BITS-1:0]     hits;
      logic [tlbpt_pkg::COUNT_BITS-1:0]     faults;
      tlbpt_pkg::rsp_type                   expected_q[$];
      int                                   errors;

      function new();
         foreach (tlb_valid[k]) begin
            tlb_page[k]  = '0;
            tlb_frame[k] = '0;
            tlb_valid[k] = 1'b0;
         end
         foreach (page_valid[p]) begin
            page_frame[p] = '0;
            page_valid[p] = 1'b0;
         end
         next_frame = '0;
         hits       = '0;
         faults     = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what);
         errors++;
         $display("%0t: translation mismatch: %s", $realtime, what);
      endtask

      // Translate one accepted request and queue the response it must produce.
      function void note_request(tlbpt_pkg::req_type item);
         tlbpt_pkg::page_idx_type           page;
         logic [tlbpt_pkg::OFFSET_BITS-1:0] offset;
         tlbpt_pkg::frame_type              frame;
         bit                                hit;
         bit                                fault;
         tlbpt_pkg::rsp_type                rsp;
         page   = tlbpt_pkg::page_idx_type'(item.logical_address >> tlbpt_pkg::OFFSET_BITS);
         offset = item.logical_address[tlbpt_pkg::OFFSET_BITS-1:0];
         frame  = '0;
         hit    = 1'b0;
         fault  = 1'b0;
         // first valid match wins, searched from the newest entry
         for (int k = 0; k < tlbpt_pkg::TLB_ENTRIES; k++) begin
            if (!hit && tlb_valid[k] && tlb_page[k] == page) begin
               hit   = 1'b1;
               frame = tlb_frame[k];
            end
         end
         if (hit) begin
            if (hits != '1) hits++;
         end else begin
            if (page_valid[page]) begin
               frame = page_frame[page];
            end else begin
               // fault: take the next frame, counter wraps and only its low bits are used
               fault            = 1'b1;
               frame            = tlbpt_pkg::frame_type'(next_frame);
               next_frame       = next_frame + 1'b1;
               page_frame[page] = frame;
               page_valid[page] = 1'b1;
               if (faults != '1) faults++;
            end
            // FIFO insert: everything moves down one, the last entry is dropped
            for (int k = tlbpt_pkg::TLB_ENTRIES - 1; k > 0; k--) begin
               tlb_page[k]  = tlb_page[k-1];
               tlb_frame[k] = tlb_frame[k-1];
               tlb_valid[k] = tlb_valid[k-1];
            end
            tlb_page[0]  = page;
            tlb_frame[0] = frame;
            tlb_valid[0] = 1'b1;
         end
         rsp.physical_address = (tlbpt_pkg::ADDR_BITS'(frame) << tlbpt_pkg::OFFSET_BITS)
                                + tlbpt_pkg::ADDR_BITS'(offset);
         rsp.tlb_hit          = hit;
         rsp.page_fault       = fault;
         rsp.hit_count        = hits;
         rsp.fault_count      = faults;
         expected_q.push_back(rsp);
      endfunction

      task check_response(tlbpt_pkg::rsp_type got);
         tlbpt_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response %h with no item pending", got));
         end else begin
            want = expected_q.pop_front();
            if (got.physical_address !== want.physical_address)
               report($sformatf("physical_address %h, expected %h",
                                got.physical_address, want.physical_address));
            if (got.tlb_hit !== want.tlb_hit)
               report($sformatf("tlb_hit %b, expected %b", got.tlb_hit, want.tlb_hit));
            if (got.page_fault !== want.page_fault)
               report($sformatf("page_fault %b, expected %b",
                                got.page_fault, want.page_fault));
            if (got.hit_count !== want.hit_count)
               report($sformatf("hit_count %0d, expected %0d",
                                got.hit_count, want.hit_count));
            if (got.fault_count !== want.fault_count)
               report($sformatf("fault_count %0d, expected %0d",
                                got.fault_count, want.fault_count));
         end
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlbpt_req_if req_ch ();
   tlbpt_rsp_if rsp_ch ();

   tlb_page_table_translator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   translation_scoreboard sb;

   // Idle rates in percent; the main sequence changes them per phase.
   int                      sender_idle_pct;
   int                      receiver_idle_pct;
   int                      phase;
   logic                    hold_off;
   int                      cycle_count = 0;
   tlbpt_pkg::page_idx_type recent_pages[$];
   tlbpt_pkg::page_idx_type hot_base;

   // ---------------------------------------------------------------------------
   // Response side: random back-pressure, plus a forced hold-off window.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ch.ready <= !hold_off && ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Long stall at the start of the no-idle phase: the receiver holds off while
   // the sender keeps offering items, so the pipeline fills and req ready drops.
   initial begin
      int held;
      hold_off = 1'b0;
      wait (phase == 3);
      @(posedge clock);
      hold_off <= 1'b1;
      for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Monitors: both channels sampled at the rising edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
   end

   // Watchdog: a lost or stuck item ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[tlb_page_table_translator] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Offer one item, idling first at the current sender rate, and hold it until
   // it is taken. valid stays high into the next call when no idle is drawn.
   task automatic send_item(input logic [tlbpt_pkg::ADDR_BITS-1:0] addr);
      tlbpt_pkg::req_type item;
      item.logical_address = addr;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      recent_pages.push_back(tlbpt_pkg::page_idx_type'(addr >> tlbpt_pkg::OFFSET_BITS));
      if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
   endtask

   // Address mix: recent pages (mostly TLB hits), a sliding window wider than the
   // TLB (misses that find the page table filled, with evictions), and any page
   // at all (faults while free pages remain). Offsets are always full range.
   function automatic logic [tlbpt_pkg::ADDR_BITS-1:0] random_address();
      int                      pick;
      tlbpt_pkg::page_idx_type page;
      pick = $urandom_range(0, 99);
      if (pick < 35 && recent_pages.size() > 0)
         page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      else if (pick < 70)
         page = hot_base + tlbpt_pkg::page_idx_type'($urandom_range(0, HOT_SPAN - 1));
      else
         page = tlbpt_pkg::page_idx_type'($urandom_range(0, tlbpt_pkg::PAGE_COUNT - 1));
      return {page, tlbpt_pkg::OFFSET_BITS'($urandom_range(0,
                                            (1 << tlbpt_pkg::OFFSET_BITS) - 1))};
   endfunction

   initial begin
      int n;
      sb                = new();
      phase             = 0;
      hot_base          = '0;
      sender_idle_pct   = 17;
      receiver_idle_pct = 49;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int p = 1; p <= 3; p++) begin
         phase = p;
         // phase 1: sender idles a little, receiver a lot; phase 2 swapped;
         // phase 3 no random idling (but the hold-off above)
         sender_idle_pct   = (p == 1) ? 17 : (p == 2) ? 49 : 0;
         receiver_idle_pct = (p == 1) ? 49 : (p == 2) ? 17 : 0;

         if (p == 1) begin
            // address extremes, then hits on the same pages with other offsets
            send_item(16'h0000);   // fault, frame 0
            send_item(16'h0000);   // hit
            send_item(16'hFFFF);   // top page, max offset: fault
            send_item(16'hFFFF);   // hit
            send_item(16'h00FF);   // page 0 hit, max offset
            send_item(16'hFF00);   // top page hit, zero offset
            // fill the TLB past capacity: page 0 falls out
            for (int k = 1; k < tlbpt_pkg::TLB_ENTRIES; k++)
               send_item({tlbpt_pkg::page_idx_type'(k), tlbpt_pkg::OFFSET_BITS'(k * 17)});
            // evicted page: TLB miss, page table hit, no new frame
            send_item(16'h0080);
            // top page also evicted by now
            send_item(16'hFF80);
            // newest of the fill pages still cached
            send_item({tlbpt_pkg::page_idx_type'(tlbpt_pkg::TLB_ENTRIES - 1), 8'h55});
         end

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 150 == 0)
               hot_base = tlbpt_pkg::page_idx_type'($urandom_range(0,
                                                    tlbpt_pkg::PAGE_COUNT - 1));
            send_item(random_address());
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then let the pipeline settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[tlb_page_table_translator] OK");
      end else begin
         $display("[tlb_page_table_translator] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tlbpt_pkg.sv
hdl/tlbpt_channels.sv
hdl/tlb_page_table_translator.sv
tb/sv/tlb_page_table_translator_test.sv
